// File: design/isml_pkg.sv
// shared types and constants for the interval set merge and lookup block
package isml_pkg;

    localparam int unsigned COVER_BITS = 51;
    localparam int unsigned HITS_BITS  = 32;
    localparam int unsigned FIELD_BITS = 50;
    localparam int unsigned COUNT_BITS = 9;
    localparam int unsigned STAT_BITS  = 2;
    localparam int unsigned OP_BITS    = 2;

    // request operation codes
    localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_BITS-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

    // result status codes
    localparam logic [STAT_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_BADRANGE = 2'd2;

    // command broadcast to every cell
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_PAIR,
        CELL_FINAL,
        CELL_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_cmd_t;

    // per-cell flags and covered-sum contribution
    typedef struct packed {
        logic                  ov;
        logic                  pair;
        logic                  hit;
        logic [COVER_BITS-1:0] delta;
    } cell_stat_t;

    // reduced view of the whole row for the sequencer
    typedef struct packed {
        logic                  any_ov;
        logic                  any_pair;
        logic                  any_hit;
        logic [COVER_BITS-1:0] delta;
    } row_stat_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN
    } ctrl_state_t;

endpackage

// File: design/isml_cell.sv
// one table cell: holds a single range and trades it with its neighbors
module isml_cell #(
    parameter int unsigned ID_BITS = 50
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  isml_pkg::cell_cmd_t          cmd,
    input  logic [ID_BITS-1:0]           new_lo,
    input  logic [ID_BITS-1:0]           new_hi,
    input  logic [ID_BITS-1:0]           query_id,
    input  logic                         prev_vld,
    input  logic [ID_BITS-1:0]           prev_lo,
    input  logic [ID_BITS-1:0]           prev_hi,
    input  logic                         prev_ov,
    input  logic                         prev_after,
    input  logic                         next_vld,
    input  logic [ID_BITS-1:0]           next_lo,
    input  logic [ID_BITS-1:0]           next_hi,
    input  logic                         next_ov,
    output logic                         vld,
    output logic [ID_BITS-1:0]           ent_lo,
    output logic [ID_BITS-1:0]           ent_hi,
    output logic                         ov,
    output logic                         after,
    output isml_pkg::cell_stat_t         stat
);
    import isml_pkg::*;

    logic               vld_reg, vld_next;
    logic [ID_BITS-1:0] lo_reg, lo_next;
    logic [ID_BITS-1:0] hi_reg, hi_next;
    logic [ID_BITS-1:0] mlo, mhi;
    logic [63:0]        gap, grow;
    logic               shift_dn;

    // local compares against the request range
    assign ov    = vld_reg && (hi_reg >= new_lo) && (lo_reg <= new_hi);
    assign after = !vld_reg || (lo_reg > new_hi);
    assign mlo   = (lo_reg < new_lo) ? lo_reg : new_lo;
    assign mhi   = (hi_reg > new_hi) ? hi_reg : new_hi;
    // cells inside or behind the merged run, and empty cells, close the gap
    assign shift_dn = prev_ov || (prev_vld && prev_after) || !vld_reg;

    // covered-sum change this cell is responsible for
    assign gap  = 64'(next_lo) - 64'(hi_reg) - 64'd1;
    assign grow = (64'(mhi) - 64'(mlo)) - (64'(hi_reg) - 64'(lo_reg));

    always_comb
    begin
        stat.ov    = ov;
        stat.pair  = ov && !prev_ov && next_ov;
        stat.hit   = vld_reg && (lo_reg <= query_id) && (query_id <= hi_reg);
        stat.delta = '0;
        if (cmd.op == CELL_PAIR && stat.pair)
        begin
            stat.delta = gap[COVER_BITS-1:0];
        end
        else if (cmd.op == CELL_FINAL && ov)
        begin
            stat.delta = grow[COVER_BITS-1:0];
        end
    end

    // next cell contents
    always_comb
    begin
        vld_next = vld_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        case (cmd.op)
            CELL_CLEAR:
            begin
                vld_next = 1'b0;
            end
            CELL_INSERT:
            begin
                if (after)
                begin
                    if (prev_after)
                    begin
                        vld_next = prev_vld;
                        lo_next  = prev_lo;
                        hi_next  = prev_hi;
                    end
                    else
                    begin
                        vld_next = 1'b1;
                        lo_next  = new_lo;
                        hi_next  = new_hi;
                    end
                end
            end
            CELL_PAIR:
            begin
                if (stat.pair)
                begin
                    hi_next = next_hi;
                end
                else if (shift_dn && !(ov && !prev_ov))
                begin
                    vld_next = next_vld;
                    lo_next  = next_lo;
                    hi_next  = next_hi;
                end
            end
            CELL_FINAL:
            begin
                if (ov)
                begin
                    lo_next = mlo;
                    hi_next = mhi;
                end
            end
            default:
            begin
                vld_next = vld_reg;
            end
        endcase
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // range payload
    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign vld    = vld_reg;
    assign ent_lo = lo_reg;
    assign ent_hi = hi_reg;

endmodule

// File: design/isml_ctrl.sv
// sequencer: takes requests, steers the cell row and builds results
module isml_ctrl #(
    parameter int unsigned MAX_RANGES = 256,
    parameter int unsigned ID_BITS    = 50
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  logic [isml_pkg::OP_BITS-1:0]          req_op,
    input  logic [ID_BITS-1:0]                    req_lo,
    input  logic [ID_BITS-1:0]                    req_hi,
    input  logic [ID_BITS-1:0]                    req_id,
    input  isml_pkg::row_stat_t                   row,
    output isml_pkg::cell_cmd_t                   cmd,
    output logic [ID_BITS-1:0]                    cur_lo,
    output logic [ID_BITS-1:0]                    cur_hi,
    output logic [ID_BITS-1:0]                    cur_id,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic                                  res_member,
    output logic [isml_pkg::HITS_BITS-1:0]        res_hits,
    output logic [isml_pkg::COVER_BITS-1:0]       res_cover,
    output logic [isml_pkg::COUNT_BITS-1:0]       res_count,
    output logic [isml_pkg::STAT_BITS-1:0]        res_status
);
    import isml_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);

    ctrl_state_t           state_reg, state_next;
    logic [OP_BITS-1:0]    op_reg;
    logic [ID_BITS-1:0]    lo_reg, hi_reg, id_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [HITS_BITS-1:0]  hits_reg, hits_next;
    logic [COVER_BITS-1:0] cov_reg, cov_next;
    logic                  ovalid_reg, ovalid_next;
    logic                  done;
    logic                  out_free;
    logic                  member;
    logic [STAT_BITS-1:0]  status;
    logic [63:0]           new_len;

    assign out_free  = !ovalid_reg || res_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign new_len   = 64'(hi_reg) - 64'(lo_reg) + 64'd1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // row command, counters and completion
    always_comb
    begin
        cmd.op    = CELL_HOLD;
        done      = 1'b0;
        member    = 1'b0;
        status    = ST_OK;
        cnt_next  = cnt_reg;
        hits_next = hits_reg;
        cov_next  = cov_reg;
        if (state_reg == S_RUN)
        begin
            case (op_reg)
                OP_INSERT:
                begin
                    if (lo_reg > hi_reg)
                    begin
                        done   = out_free;
                        status = ST_BADRANGE;
                    end
                    else if (row.any_pair)
                    begin
                        cmd.op   = CELL_PAIR;
                        cnt_next = cnt_reg - 1'b1;
                        cov_next = cov_reg + row.delta;
                    end
                    else if (row.any_ov)
                    begin
                        done = out_free;
                        if (out_free)
                        begin
                            cmd.op   = CELL_FINAL;
                            cov_next = cov_reg + row.delta;
                        end
                    end
                    else if (cnt_reg == CNT_W'(MAX_RANGES))
                    begin
                        done   = out_free;
                        status = ST_FULL;
                    end
                    else
                    begin
                        done = out_free;
                        if (out_free)
                        begin
                            cmd.op   = CELL_INSERT;
                            cnt_next = cnt_reg + 1'b1;
                            cov_next = cov_reg + new_len[COVER_BITS-1:0];
                        end
                    end
                end
                OP_QUERY:
                begin
                    done   = out_free;
                    member = row.any_hit;
                    if (out_free && row.any_hit && (hits_reg != '1))
                    begin
                        hits_next = hits_reg + 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    done = out_free;
                    if (out_free)
                    begin
                        cmd.op    = CELL_CLEAR;
                        cnt_next  = '0;
                        hits_next = '0;
                        cov_next  = '0;
                    end
                end
                default:
                begin
                    done = out_free;
                end
            endcase
        end
    end

    // result slot
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (res_ready)
        begin
            ovalid_next = 1'b0;
        end
        if (done)
        begin
            ovalid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            hits_reg   <= '0;
            cov_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            hits_reg   <= hits_next;
            cov_reg    <= cov_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            op_reg <= req_op;
            lo_reg <= req_lo;
            hi_reg <= req_hi;
            id_reg <= req_id;
        end
        if (done)
        begin
            res_member <= member;
            res_status <= status;
            res_hits   <= hits_next;
            res_cover  <= cov_next;
            res_count  <= COUNT_BITS'(cnt_next);
        end
    end

    assign cur_lo    = lo_reg;
    assign cur_hi    = hi_reg;
    assign cur_id    = id_reg;
    assign res_valid = ovalid_reg;

endmodule

// File: design/interval_set_merge_lookup.sv
// top level: interval table built from a row of range cells
//
// Usage notes
//  - requests enter on s_tvalid/s_tready/s_tdata: operation, range start, range end,
//    query id. one result per request leaves on m_tvalid/m_tready/m_tdata.
//  - the table is a row of MAX_RANGES cells kept sorted by start; every cell
//    compares its range with the request in parallel and trades ranges with
//    its neighbors to open or close a slot.
//  - query, clear and a non-overlapping insert need no merge steps; an insert that
//    overlaps stored ranges takes one cell-row merge step per absorbed range, then
//    a final step that writes the merged range.
//  - s_tready is high while no request is in progress; the next request is
//    taken while a finished result still waits in the output register.
//  - if the receiver stalls, the request in progress waits for the output register to
//    free before its last change to the table; overlapping-insert merge steps go on.
//  - reset empties the table and zeroes hit count and covered total at once,
//    with no clearing pass.
module interval_set_merge_lookup #(
    parameter int unsigned MAX_RANGES = 256,
    parameter int unsigned ID_BITS    = 50
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[1:0], range_start[51:2], range_end[101:52], query_id[151:102]
    input  logic [151:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // is_member[0], hit_count[32:1], covered_total[83:33], entry_count[92:84],
    // status[94:93], zero fill[95]
    output logic [95:0]  m_tdata
);
    import isml_pkg::*;

    cell_cmd_t             cmd;
    row_stat_t             row;
    logic [ID_BITS-1:0]    cur_lo, cur_hi, cur_id;
    logic                  vld   [MAX_RANGES];
    logic [ID_BITS-1:0]    elo   [MAX_RANGES];
    logic [ID_BITS-1:0]    ehi   [MAX_RANGES];
    logic                  ov    [MAX_RANGES];
    logic                  aft   [MAX_RANGES];
    cell_stat_t            cstat [MAX_RANGES];
    logic                  res_member;
    logic [HITS_BITS-1:0]  res_hits;
    logic [COVER_BITS-1:0] res_cover;
    logic [COUNT_BITS-1:0] res_count;
    logic [STAT_BITS-1:0]  res_status;

    isml_ctrl #(
        .MAX_RANGES (MAX_RANGES),
        .ID_BITS    (ID_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req_op     (s_tdata[1:0]),
        .req_lo     (s_tdata[2 +: ID_BITS]),
        .req_hi     (s_tdata[52 +: ID_BITS]),
        .req_id     (s_tdata[102 +: ID_BITS]),
        .row        (row),
        .cmd        (cmd),
        .cur_lo     (cur_lo),
        .cur_hi     (cur_hi),
        .cur_id     (cur_id),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_member (res_member),
        .res_hits   (res_hits),
        .res_cover  (res_cover),
        .res_count  (res_count),
        .res_status (res_status)
    );

    // row of cells, end cells see empty neighbors
    for (genvar i = 0; i < MAX_RANGES; i++)
    begin : g_cell
        logic               p_vld, p_ov, p_aft, n_vld, n_ov;
        logic [ID_BITS-1:0] p_lo, p_hi, n_lo, n_hi;

        if (i == 0)
        begin : g_first
            assign p_vld = 1'b0;
            assign p_lo  = '0;
            assign p_hi  = '0;
            assign p_ov  = 1'b0;
            assign p_aft = 1'b0;
        end
        else
        begin : g_mid
            assign p_vld = vld[i-1];
            assign p_lo  = elo[i-1];
            assign p_hi  = ehi[i-1];
            assign p_ov  = ov[i-1];
            assign p_aft = aft[i-1];
        end

        if (i == MAX_RANGES - 1)
        begin : g_last
            assign n_vld = 1'b0;
            assign n_lo  = '0;
            assign n_hi  = '0;
            assign n_ov  = 1'b0;
        end
        else
        begin : g_inner
            assign n_vld = vld[i+1];
            assign n_lo  = elo[i+1];
            assign n_hi  = ehi[i+1];
            assign n_ov  = ov[i+1];
        end

        isml_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .new_lo     (cur_lo),
            .new_hi     (cur_hi),
            .query_id   (cur_id),
            .prev_vld   (p_vld),
            .prev_lo    (p_lo),
            .prev_hi    (p_hi),
            .prev_ov    (p_ov),
            .prev_after (p_aft),
            .next_vld   (n_vld),
            .next_lo    (n_lo),
            .next_hi    (n_hi),
            .next_ov    (n_ov),
            .vld        (vld[i]),
            .ent_lo     (elo[i]),
            .ent_hi     (ehi[i]),
            .ov         (ov[i]),
            .after      (aft[i]),
            .stat       (cstat[i])
        );
    end

    // or-reduce cell flags; at most one cell drives a nonzero delta
    always_comb
    begin
        row = '0;
        for (int i = 0; i < MAX_RANGES; i++)
        begin
            row.any_ov   = row.any_ov   | cstat[i].ov;
            row.any_pair = row.any_pair | cstat[i].pair;
            row.any_hit  = row.any_hit  | cstat[i].hit;
            row.delta    = row.delta    | cstat[i].delta;
        end
    end

    assign m_tdata = {1'b0, res_status, res_count, res_cover, res_hits, res_member};

`ifndef NO_ASSERTIONS
    // table never reports more entries than cells
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[92:84] <= COUNT_BITS'(MAX_RANGES)))
        else $error("entry count above table size");

    // results never carry the unused status code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[94:93] != 2'd3))
        else $error("bad status code");

    // membership is only reported with ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[94:93] == ST_OK))
        else $error("member flag with error status");

    // a new request is only taken with the sequencer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while busy");
`endif

endmodule

// File: dv/interval_set_merge_lookup_tb.sv
// testbench for the interval set merge and lookup block: queued requests, predicted results
`timescale 1ns / 1ps

module interval_set_merge_lookup_tb;
    import isml_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam logic [49:0] ID_MASK = '1;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [49:0] qid;
        logic [49:0] hi;
        logic [49:0] lo;
        logic [1:0]  op;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  entries;
        logic [50:0] covered;
        logic [31:0] hits;
        logic        member;
    } answer_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;

    interval_set_merge_lookup DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // shadow interval table
    logic [49:0] tbl_lo [TABLE_DEPTH];
    logic [49:0] tbl_hi [TABLE_DEPTH];
    int unsigned tbl_count = 0;
    logic [31:0] tbl_hits = '0;
    logic [50:0] tbl_cover = '0;

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    int       error_count = 0;
    int       send_idle_pct;
    int       recv_stall_pct;
    bit       hold_sender;
    longint   cycle_count = 0;
    int       answers_seen = 0;

    function automatic logic [1:0] merge_range(logic [49:0] lo_in, logic [49:0] hi_in);
        int unsigned first;
        int unsigned past;
        int unsigned shift;
        logic [49:0] lo;
        logic [49:0] hi;
        lo = lo_in;
        hi = hi_in;
        if (lo > hi)
            return ST_BADRANGE;
        first = 0;
        while (first < tbl_count && tbl_hi[first] < lo)
            first++;
        past = first;
        while (past < tbl_count && tbl_lo[past] <= hi)
            past++;
        if (past == first)
        begin
            if (tbl_count >= TABLE_DEPTH)
                return ST_FULL;
            for (int m = tbl_count; m > first; m--)
            begin
                tbl_lo[m] = tbl_lo[m-1];
                tbl_hi[m] = tbl_hi[m-1];
            end
            tbl_lo[first] = lo;
            tbl_hi[first] = hi;
            tbl_count++;
            tbl_cover = tbl_cover + 51'(hi - lo) + 51'd1;
            return ST_OK;
        end
        if (tbl_lo[first] < lo)
            lo = tbl_lo[first];
        if (tbl_hi[past-1] > hi)
            hi = tbl_hi[past-1];
        for (int m = first; m < past; m++)
            tbl_cover = tbl_cover - 51'(tbl_hi[m] - tbl_lo[m]) - 51'd1;
        tbl_lo[first] = lo;
        tbl_hi[first] = hi;
        shift = past - first - 1;
        if (shift > 0)
        begin
            for (int m = first + 1; m + shift < tbl_count; m++)
            begin
                tbl_lo[m] = tbl_lo[m+shift];
                tbl_hi[m] = tbl_hi[m+shift];
            end
            tbl_count = tbl_count - shift;
        end
        tbl_cover = tbl_cover + 51'(hi - lo) + 51'd1;
        return ST_OK;
    endfunction

    function automatic bit lookup_id(logic [49:0] id);
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_lo[i] > id)
                return 0;
            if (id <= tbl_hi[i])
                return 1;
        end
        return 0;
    endfunction

    // predict the answer of one accepted request
    function automatic answer_t predict_answer(request_t rq);
        answer_t a;
        a = '0;
        if (rq.op == OP_INSERT)
            a.status = merge_range(rq.lo, rq.hi);
        else if (rq.op == OP_QUERY)
        begin
            if (lookup_id(rq.qid))
            begin
                a.member = 1'b1;
                if (tbl_hits != 32'hFFFF_FFFF)
                    tbl_hits++;
            end
        end
        else if (rq.op == OP_CLEAR)
        begin
            tbl_count = 0;
            tbl_hits  = '0;
            tbl_cover = '0;
        end
        a.hits    = tbl_hits;
        a.covered = tbl_cover;
        a.entries = 9'(tbl_count);
        return a;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want, cycle_count);
    endtask

    // append one request to the pending queue
    task automatic add_request(request_t r);
        pending_requests.insert(pending_requests.size(), r);
    endtask

    function automatic logic [49:0] rand_id();
        return 50'({$urandom, $urandom});
    endfunction

    function automatic request_t make_req(logic [1:0] op, logic [49:0] lo, logic [49:0] hi,
                                          logic [49:0] qid);
        request_t r;
        r.op = op; r.lo = lo; r.hi = hi; r.qid = qid;
        return r;
    endfunction

    // random request from a small id window so ranges overlap and queries hit
    function automatic request_t rand_req(int span);
        request_t r;
        logic [49:0] base;
        int k;
        base = ($urandom_range(0, 3) == 0) ? rand_id() : 50'd0;
        k = $urandom_range(0, 99);
        r.qid = rand_id();
        r.lo = rand_id();
        r.hi = rand_id();
        if (k < 55)
        begin
            r.op = OP_INSERT;
            r.lo = base + 50'($urandom_range(0, span));
            r.hi = r.lo + 50'($urandom_range(0, span / 16));
            if ($urandom_range(0, 19) == 0)
                r.hi = r.lo - 50'($urandom_range(1, 5));
        end
        else if (k < 96)
        begin
            r.op = OP_QUERY;
            if ($urandom_range(0, 4) != 0)
                r.qid = 50'($urandom_range(0, span + span / 16));
        end
        else if (k < 98)
            r.op = OP_CLEAR;
        else
            r.op = 2'd3;
        return r;
    endfunction

    // clock
    always
    begin
        clk = 1'b0; #6;
        clk = 1'b1; #6;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (!s_tvalid || s_tready)
            begin
                if (pending_requests.size() > 0 && !hold_sender &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_requests.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
            if (s_tvalid && s_tready)
                expected_answers.insert(expected_answers.size(),
                                        predict_answer(request_t'(s_tdata)));
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (m_tvalid && m_tready)
            begin
                answer_t got;
                answer_t want;
                got = answer_t'(m_tdata[94:0]);
                answers_seen++;
                if (expected_answers.size() == 0)
                    report_mismatch("unexpected result", longint'(got.covered), 0);
                else
                begin
                    want = expected_answers.pop_front();
                    if (got.member !== want.member)
                        report_mismatch("is_member", got.member, want.member);
                    if (got.hits !== want.hits)
                        report_mismatch("hit_count", got.hits, want.hits);
                    if (got.covered !== want.covered)
                        report_mismatch("covered_total", got.covered, want.covered);
                    if (got.entries !== want.entries)
                        report_mismatch("entry_count", got.entries, want.entries);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                end
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("interval_set_merge_lookup verification failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_requests.size() > 0 || s_tvalid || expected_answers.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_sender = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, touching and overlapping ranges, bad range, op 3
        add_request(make_req(OP_QUERY, 0, 0, 0));
        add_request(make_req(OP_INSERT, 0, ID_MASK, 0));
        add_request(make_req(OP_QUERY, 0, 0, ID_MASK));
        add_request(make_req(OP_CLEAR, ID_MASK, ID_MASK, ID_MASK));
        add_request(make_req(OP_INSERT, 10, 20, 0));
        add_request(make_req(OP_INSERT, 21, 30, 0));
        add_request(make_req(OP_INSERT, 40, 50, 0));
        add_request(make_req(OP_INSERT, 60, 70, 0));
        add_request(make_req(OP_INSERT, 15, 65, 0));
        add_request(make_req(OP_INSERT, 9, 5, 0));
        add_request(make_req(OP_INSERT, ID_MASK, ID_MASK, 0));
        add_request(make_req(OP_QUERY, 0, 0, 9));
        add_request(make_req(OP_QUERY, 0, 0, 10));
        add_request(make_req(OP_QUERY, 0, 0, 70));
        add_request(make_req(OP_QUERY, 0, 0, 71));
        add_request(make_req(2'd3, ID_MASK, 0, ID_MASK));
        add_request(make_req(OP_INSERT, ID_MASK, 0, 0));
        wait_drained();

        // fill the table to capacity, then hit the full case
        add_request(make_req(OP_CLEAR, 0, 0, 0));
        for (int i = 0; i < TABLE_DEPTH; i++)
            add_request(make_req(OP_INSERT, 50'(i * 4), 50'(i * 4 + 1), 0));
        add_request(make_req(OP_INSERT, 50'd2000, 50'd2001, 0));
        add_request(make_req(OP_INSERT, 50'd2, 50'd2, 0));
        add_request(make_req(OP_INSERT, 50'd1, 50'd1020, 0));
        add_request(make_req(OP_QUERY, 0, 0, 50'd500));
        wait_drained();

        // random phases with different idle patterns
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 28 : 68) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 28 : 68) : 0;
            for (int i = 0; i < 360; i++)
            begin
                add_request(rand_req((i % 3 == 0) ? 4000 : 300));
                if (i == 180)
                begin
                    // sender waits until every result has arrived
                    while (pending_requests.size() > 0 || s_tvalid)
                        @(posedge clk);
                    hold_sender = 1;
                    wait_drained();
                    repeat (20) @(posedge clk);
                    hold_sender = 0;
                end
            end
            wait_drained();
        end

        // drive the hit counter far enough to exercise repeated hits
        send_idle_pct = 0;
        recv_stall_pct = 0;
        add_request(make_req(OP_INSERT, 0, ID_MASK, 0));
        for (int i = 0; i < 50; i++)
            add_request(make_req(OP_QUERY, 0, 0, rand_id()));
        wait_drained();
        repeat (300) @(posedge clk);

        $display("covered %0d results over directed, table-full and four idling phases",
                 answers_seen);
        if (error_count == 0 && expected_answers.size() == 0)
            $display("interval_set_merge_lookup verification clean");
        else
            $display("interval_set_merge_lookup verification failed");
        $finish;
    end
endmodule
